// ===== hdl/cma_pkg.sv =====
package cma_pkg;

   // Array sizes and counter width
   localparam int MAX_ROWS    = 32;
   localparam int MAX_COLUMNS = 32;
   localparam int COUNT_WIDTH = 32;

   // Fixed field widths
   localparam int IDX_W  = 5;
   localparam int SIZE_W = 6;
   localparam int OUT_W  = 32;

   localparam int ROW_AW     = $clog2(MAX_ROWS);
   localparam int COL_AW     = $clog2(MAX_COLUMNS);
   localparam int CELL_DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int CELL_AW    = $clog2(CELL_DEPTH);

   // Stream payload widths
   localparam int REQ_DATA_W = 16;            // 2 * IDX_W, padded to bytes
   localparam int RSP_DATA_W = 5 * OUT_W;

   // Configuration port
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS_IN_USE = CSR_IDX_W'(1);
   localparam logic [SIZE_W-1:0]    SIZE_RESET         = SIZE_W'(32);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam count_type COUNT_MAX = '1;

   typedef enum logic {
      ACT_ADD   = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_SAT   = 2'd2
   } status_type;

   // Counter update issued by the execute stage
   typedef struct packed {
      logic             bump;
      logic [IDX_W-1:0] stim;
      logic [IDX_W-1:0] resp;
   } upd_type;

   // Current running sums seen by the execute stage
   typedef struct packed {
      count_type row;
      count_type col;
      count_type entry;
      count_type diag;
   } sum_view_type;

   function automatic logic is_full(input count_type c);
      return c == COUNT_MAX;
   endfunction

   function automatic count_type sat_inc(input count_type c);
      return is_full(c) ? c : count_type'(c + count_type'(1));
   endfunction

   function automatic logic [CELL_AW-1:0] cell_addr(input logic [IDX_W-1:0] stim,
                                                    input logic [IDX_W-1:0] resp);
      return CELL_AW'(CELL_AW'(ROW_AW'(stim)) * CELL_AW'(MAX_COLUMNS))
           + CELL_AW'(COL_AW'(resp));
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input count_type c);
      return OUT_W'(c);
   endfunction

endpackage

// ===== hdl/cma_cell_store.sv =====
module cma_cell_store
   import cma_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_stim,
   input  logic [IDX_W-1:0] rd_resp,
   input  upd_type          upd,
   input  count_type        upd_count,
   output count_type        cell_old,
   output logic             clear_busy
);

   count_type mem [CELL_DEPTH];

   logic               wr_en;
   logic [CELL_AW-1:0] wr_addr;
   count_type          wr_data;
   logic [CELL_AW-1:0] rd_addr;

   count_type          rd_data_ff;
   logic               fwd_hit_ff;
   count_type          fwd_data_ff;
   logic [CELL_AW-1:0] clr_addr_ff;
   logic [CELL_AW-1:0] clr_addr_in;
   logic               clear_busy_ff;
   logic               clear_busy_in;

   // clear sweep owns the write port after reset
   always_comb begin
      if (clear_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = upd.bump;
         wr_addr = cell_addr(upd.stim, upd.resp);
         wr_data = upd_count;
      end
   end

   assign rd_addr       = cell_addr(rd_stim, rd_resp);
   assign clr_addr_in   = clear_busy_ff ? CELL_AW'(clr_addr_ff + 1'b1) : clr_addr_ff;
   assign clear_busy_in = clear_busy_ff && (clr_addr_ff != CELL_AW'(CELL_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         clear_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff   <= clr_addr_in;
         clear_busy_ff <= clear_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read is old-data; a same-cycle write to the same cell is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign cell_old   = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule

// ===== hdl/cma_sums.sv =====
module cma_sums
   import cma_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  upd_type      upd,
   output sum_view_type view
);

   count_type row_sums_ff [MAX_ROWS];
   count_type col_sums_ff [MAX_COLUMNS];
   count_type entry_ff;
   count_type diag_ff;

   logic [ROW_AW-1:0] row_idx;
   logic [COL_AW-1:0] col_idx;
   logic              diag_hit;

   assign row_idx  = ROW_AW'(upd.stim);
   assign col_idx  = COL_AW'(upd.resp);
   assign diag_hit = upd.stim == upd.resp;

   assign view.row   = row_sums_ff[row_idx];
   assign view.col   = col_sums_ff[col_idx];
   assign view.entry = entry_ff;
   assign view.diag  = diag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ROWS; i++) begin
            row_sums_ff[i] <= '0;
         end
         for (int j = 0; j < MAX_COLUMNS; j++) begin
            col_sums_ff[j] <= '0;
         end
         entry_ff <= '0;
         diag_ff  <= '0;
      end else if (upd.bump) begin
         row_sums_ff[row_idx] <= sat_inc(view.row);
         col_sums_ff[col_idx] <= sat_inc(view.col);
         entry_ff             <= sat_inc(entry_ff);
         if (diag_hit) begin
            diag_ff <= sat_inc(diag_ff);
         end
      end
   end

endmodule

// ===== hdl/confusion_matrix_accumulator.sv =====
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tdata: stimulus_index, response_index; tuser: action
// rsp      out  rsp_tvalid/tready     tdata: cell, row, column, grand, correct; tuser: status
// csr      in   csr_valid/csr_ready   csr_index, csr_wdata (rows_in_use, columns_in_use)
//
// One item per cycle sustained unless rsp stalls; execute stage feeds the result register.
// The cell memory read is registered at accept; the execute stage does the
// read-modify-write of the cell and all running sums, forwarding the last write.
// Synchronous reset; afterward a clearing pass zeroes the 1024-entry cell memory,
// one entry per cycle, with req_tready low. csr writes are always taken.
// A stalled rsp holds the execute stage; req_tready stays high while the stage can move.
module confusion_matrix_accumulator
   import cma_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [4:0] stimulus_index, [9:5] response_index
   input  logic                  req_tuser,   // [0] action
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // cell_count, row_total, column_total,
                                              // grand_total, correct_total (32 b each)
   output logic [1:0]            rsp_tuser,   // [1:0] status
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]     csr_wdata
);

   logic [IDX_W-1:0] in_stim;
   logic [IDX_W-1:0] in_resp;
   logic             in_ok;
   logic             req_fire;
   logic             a_adv;
   logic             clear_busy;

   // config
   logic [SIZE_W-1:0] rows_in_use_ff;
   logic [SIZE_W-1:0] cols_in_use_ff;

   // execute stage
   logic             a_valid_ff;
   logic             a_valid_in;
   action_type       a_action_ff;
   logic [IDX_W-1:0] a_stim_ff;
   logic [IDX_W-1:0] a_resp_ff;
   logic             a_ok_ff;

   upd_type          upd;
   count_type        cell_old;
   count_type        cell_new;
   sum_view_type     view;
   logic             diag_hit;
   logic             sat;

   // result register
   logic             rsp_tvalid_ff;
   logic             rsp_tvalid_in;
   logic [OUT_W-1:0] rsp_cell_ff,    rsp_cell_in;
   logic [OUT_W-1:0] rsp_row_ff,     rsp_row_in;
   logic [OUT_W-1:0] rsp_col_ff,     rsp_col_in;
   logic [OUT_W-1:0] rsp_grand_ff,   rsp_grand_in;
   logic [OUT_W-1:0] rsp_correct_ff, rsp_correct_in;
   status_type       rsp_status_ff,  rsp_status_in;

   assign in_stim = req_tdata[IDX_W-1:0];
   assign in_resp = req_tdata[2*IDX_W-1:IDX_W];

   // range check against size registers capped at array size
   assign in_ok = (int'(in_stim) < int'(rows_in_use_ff)) && (int'(in_stim) < MAX_ROWS)
               && (int'(in_resp) < int'(cols_in_use_ff)) && (int'(in_resp) < MAX_COLUMNS);

   assign a_adv      = a_valid_ff && (!rsp_tvalid_ff || rsp_tready);
   assign req_tready = !clear_busy && (!a_valid_ff || a_adv);
   assign req_fire   = req_tvalid && req_tready;
   assign a_valid_in = req_fire ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);

   // ---- config writes ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= SIZE_RESET;
         cols_in_use_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_ROWS_IN_USE) begin
            rows_in_use_ff <= csr_wdata;
         end
         if (csr_index == CSR_COLUMNS_IN_USE) begin
            cols_in_use_ff <= csr_wdata;
         end
      end
   end

   // ---- input register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_action_ff <= action_type'(req_tuser);
         a_stim_ff   <= in_stim;
         a_resp_ff   <= in_resp;
         a_ok_ff     <= in_ok;
      end
   end

   // ---- counter storage ----
   assign upd.bump = a_adv && a_ok_ff && (a_action_ff == ACT_ADD);
   assign upd.stim = a_stim_ff;
   assign upd.resp = a_resp_ff;

   cma_cell_store u_cell_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_fire),
      .rd_stim    (in_stim),
      .rd_resp    (in_resp),
      .upd        (upd),
      .upd_count  (cell_new),
      .cell_old   (cell_old),
      .clear_busy (clear_busy)
   );

   cma_sums u_sums (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .view  (view)
   );

   // ---- execute: saturating increments and result select ----
   assign cell_new = sat_inc(cell_old);
   assign diag_hit = a_stim_ff == a_resp_ff;
   // any touched counter already full flags saturation; the rest still count
   assign sat = is_full(cell_old) || is_full(view.row) || is_full(view.col)
             || is_full(view.entry) || (diag_hit && is_full(view.diag));

   always_comb begin
      rsp_grand_in   = to_out(view.entry);
      rsp_correct_in = to_out(view.diag);
      if (!a_ok_ff) begin
         // out of range: nothing changes, per-cell fields read zero
         rsp_cell_in   = '0;
         rsp_row_in    = '0;
         rsp_col_in    = '0;
         rsp_status_in = STATUS_RANGE;
      end else if (a_action_ff == ACT_ADD) begin
         rsp_cell_in    = to_out(cell_new);
         rsp_row_in     = to_out(sat_inc(view.row));
         rsp_col_in     = to_out(sat_inc(view.col));
         rsp_grand_in   = to_out(sat_inc(view.entry));
         rsp_correct_in = diag_hit ? to_out(sat_inc(view.diag)) : to_out(view.diag);
         rsp_status_in  = sat ? STATUS_SAT : STATUS_OK;
      end else begin
         rsp_cell_in   = to_out(cell_old);
         rsp_row_in    = to_out(view.row);
         rsp_col_in    = to_out(view.col);
         rsp_status_in = STATUS_OK;
      end
   end

   // ---- result register ----
   assign rsp_tvalid_in = a_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         rsp_cell_ff    <= rsp_cell_in;
         rsp_row_ff     <= rsp_row_in;
         rsp_col_ff     <= rsp_col_in;
         rsp_grand_ff   <= rsp_grand_in;
         rsp_correct_ff <= rsp_correct_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_correct_ff, rsp_grand_ff, rsp_col_ff, rsp_row_ff, rsp_cell_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== hdl/cma_checker.sv =====
module cma_checker
   import cma_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   // a result is only dropped by a transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped without transfer");

   // fresh result follows a request transfer through the execute stage and result register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without matching request");

   // memory clearing pass blocks requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready && !rsp_tvalid)
      else $error("request taken or result shown during clearing");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_RANGE) |-> rsp_tdata[3*OUT_W-1:0] == '0)
      else $error("out-of-range result carries cell data");

   a_correct_le_grand: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5*OUT_W-1:4*OUT_W] <= rsp_tdata[4*OUT_W-1:3*OUT_W])
      else $error("correct total exceeds grand total");

endmodule

bind confusion_matrix_accumulator cma_checker u_cma_checker (.*);

// ===== dv/tb_confusion_matrix_accumulator.sv =====
module tb_confusion_matrix_accumulator;
   timeunit 1ns;
   timeprecision 1ps;

   import cma_pkg::*;

   // Cycles with no transfer on any channel before the run is declared hung.
   // Covers the clearing pass after reset and the long output hold-off.
   localparam int STALL_LIMIT = 4000;
   // Length of the forced output stall in the back-pressure test.
   localparam int HOLD_LEN    = 250;
   // Extra cycles after the last result.
   localparam int TAIL_CYCLES = 8;

   // Expected contents of one result transfer
   typedef struct packed {
      count_type  cell_cnt;
      count_type  row;
      count_type  col;
      count_type  grand;
      count_type  correct;
      status_type status;
   } tally_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [SIZE_W-1:0]     csr_wdata  = '0;

   // Traffic shaping knobs
   int   req_idle_pct = 0;     // only touched by the stimulus process
   int   rsp_idle_pct = 0;     // written with NBA, read by the receiver
   logic hold_flip    = 1'b0;  // toggling it starts one long output stall

   // Scoreboard state
   tally_type tally_expect[$];
   int        mismatches   = 0;
   int        items_sent   = 0;
   int        results_seen = 0;
   int        quiet_cycles = 0;

   // Shadow copy of the matrix, the running sums and the size registers
   count_type        cell_tally [MAX_ROWS][MAX_COLUMNS];
   count_type        row_tally  [MAX_ROWS];
   count_type        col_tally  [MAX_COLUMNS];
   count_type        entry_tally;
   count_type        diag_tally;
   logic [SIZE_W-1:0] rows_cfg;
   logic [SIZE_W-1:0] cols_cfg;

   confusion_matrix_accumulator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Saturating increment; flags a counter that was already full.
   task automatic bump_count(inout count_type c, inout logic full_seen);
      if (c == COUNT_MAX)
         full_seen = 1'b1;
      else
         c = c + 1'b1;
   endtask

   // Applies one request to the shadow state and builds the expected result.
   task automatic tally_entry(input action_type act, input logic [IDX_W-1:0] stim,
                              input logic [IDX_W-1:0] resp, output tally_type res);
      int   rows_eff;
      int   cols_eff;
      logic full_seen;
      rows_eff  = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
      cols_eff  = (cols_cfg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_cfg);
      full_seen = 1'b0;
      res       = '0;
      if (int'(stim) >= rows_eff || int'(resp) >= cols_eff) begin
         // out of range: no update, addressed fields read as zero
         res.status = STATUS_RANGE;
      end else begin
         if (act == ACT_ADD) begin
            bump_count(cell_tally[stim][resp], full_seen);
            bump_count(row_tally[stim], full_seen);
            bump_count(col_tally[resp], full_seen);
            bump_count(entry_tally, full_seen);
            if (stim == resp)
               bump_count(diag_tally, full_seen);
         end
         res.cell_cnt = cell_tally[stim][resp];
         res.row      = row_tally[stim];
         res.col      = col_tally[resp];
         res.status   = full_seen ? STATUS_SAT : STATUS_OK;
      end
      res.grand   = entry_tally;
      res.correct = diag_tally;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Monitor: register writes, request transfers and result checks all
   // happen in this one process, so the shadow state sees them in order.
   // Everything sampled here is the pre-edge value.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      tally_type want;
      tally_type got;
      logic      moved;
      if (reset) begin
         foreach (cell_tally[r, c]) cell_tally[r][c] = '0;
         foreach (row_tally[r]) row_tally[r] = '0;
         foreach (col_tally[c]) col_tally[c] = '0;
         entry_tally = '0;
         diag_tally  = '0;
         rows_cfg    = SIZE_RESET;
         cols_cfg    = SIZE_RESET;
      end else begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               CSR_ROWS_IN_USE:    rows_cfg = csr_wdata;
               CSR_COLUMNS_IN_USE: cols_cfg = csr_wdata;
               default: ;  // unknown index: ignored by the block
            endcase
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            tally_entry(action_type'(req_tuser), req_tdata[IDX_W-1:0],
                        req_tdata[2*IDX_W-1:IDX_W], want);
            tally_expect.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            results_seen++;
            got.cell_cnt = rsp_tdata[0*OUT_W +: OUT_W];
            got.row      = rsp_tdata[1*OUT_W +: OUT_W];
            got.col      = rsp_tdata[2*OUT_W +: OUT_W];
            got.grand    = rsp_tdata[3*OUT_W +: OUT_W];
            got.correct  = rsp_tdata[4*OUT_W +: OUT_W];
            got.status   = status_type'(rsp_tuser);
            if (tally_expect.size() == 0) begin
               report_mismatch("result with nothing pending, cell", got.cell_cnt, '0);
            end else begin
               want = tally_expect.pop_front();
               if (got.cell_cnt !== want.cell_cnt)
                  report_mismatch("cell_count", got.cell_cnt, want.cell_cnt);
               if (got.row !== want.row)
                  report_mismatch("row_total", got.row, want.row);
               if (got.col !== want.col)
                  report_mismatch("column_total", got.col, want.col);
               if (got.grand !== want.grand)
                  report_mismatch("grand_total", got.grand, want.grand);
               if (got.correct !== want.correct)
                  report_mismatch("correct_total", got.correct, want.correct);
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
            end
         end
         // watchdog: any transfer restarts the count
         if (moved)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random rsp_tready, plus a long hold-off each time
   // hold_flip toggles.
   // ------------------------------------------------------------------
   logic hold_seen = 1'b0;
   int   hold_left = 0;

   always @(posedge clock) begin
      if (hold_flip != hold_seen) begin
         hold_seen  <= hold_flip;
         hold_left  <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers. All are entered at a rising edge; tvalid stays
   // high across back-to-back transfers so it is never lowered and raised
   // in the same step.
   // ------------------------------------------------------------------

   // Offers one request and returns at the edge where it transfers.
   // Each cycle slot idles with probability req_idle_pct.
   task automatic send_req(input action_type act, input logic [IDX_W-1:0] stim,
                           input logic [IDX_W-1:0] resp);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({resp, stim});
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Stops offering and waits until every request has its result back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Resizes the matrix with the block idle; optionally pokes an unknown index too.
   task automatic set_sizes(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                            input bit poke_unknown);
      drain();
      if (poke_unknown)
         csr_write(CSR_IDX_W'($urandom_range(int'(CSR_COLUMNS_IN_USE) + 1,
                                             2**CSR_IDX_W - 1)),
                   SIZE_W'($urandom));
      csr_write(CSR_ROWS_IN_USE, rows);
      csr_write(CSR_COLUMNS_IN_USE, cols);
      csr_valid <= 1'b0;
   endtask

   // Mostly small and mid sizes, sometimes zero, full, or above the cap.
   function automatic logic [SIZE_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5)
         return '0;
      else if (roll < 15)
         return SIZE_W'($urandom_range(MAX_ROWS + 1, 2**SIZE_W - 1));
      else if (roll < 25)
         return SIZE_W'(MAX_ROWS);
      else if (roll < 35)
         return SIZE_W'(1);
      else
         return SIZE_W'($urandom_range(2, MAX_ROWS - 1));
   endfunction

   // Index biased into the valid range; some land anywhere to hit range errors.
   function automatic logic [IDX_W-1:0] pick_index(input logic [SIZE_W-1:0] size_cfg);
      int span;
      span = (size_cfg > MAX_ROWS) ? MAX_ROWS : int'(size_cfg);
      if (span == 0 || $urandom_range(99) < 15)
         return IDX_W'($urandom_range(2**IDX_W - 1));
      return IDX_W'($urandom_range(span - 1));
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Corner cells, reset sizes, zero sizes, capped sizes, resizing with
   // stale counts, and an unknown register index.
   task automatic test_directed();
      req_idle_pct = 0;
      rsp_idle_pct <= 50;
      // reset sizes (32 x 32)
      send_req(ACT_QUERY, 5'd0, 5'd0);       // empty matrix
      send_req(ACT_ADD, 5'd0, 5'd0);
      send_req(ACT_ADD, 5'd0, 5'd0);         // back-to-back on one cell
      send_req(ACT_ADD, 5'd31, 5'd31);
      send_req(ACT_ADD, 5'd0, 5'd31);
      send_req(ACT_ADD, 5'd31, 5'd0);
      send_req(ACT_QUERY, 5'd31, 5'd31);
      send_req(ACT_ADD, 5'd21, 5'd10);       // alternating bit patterns
      send_req(ACT_ADD, 5'd10, 5'd21);
      // zero size: every index is out of range
      set_sizes('0, '0, 1'b0);
      send_req(ACT_ADD, 5'd0, 5'd0);
      send_req(ACT_QUERY, 5'd5, 5'd5);
      // above the cap acts as full size; also an ignored register write
      set_sizes('1, '1, 1'b1);
      send_req(ACT_ADD, 5'd31, 5'd31);
      send_req(ACT_QUERY, 5'd31, 5'd0);
      // one by one
      set_sizes(SIZE_W'(1), SIZE_W'(1), 1'b0);
      send_req(ACT_ADD, 5'd0, 5'd0);
      send_req(ACT_ADD, 5'd1, 5'd0);
      send_req(ACT_ADD, 5'd0, 5'd1);
      send_req(ACT_QUERY, 5'd0, 5'd0);
      // uneven resize: old counts stay in the totals
      set_sizes(SIZE_W'(5), SIZE_W'(3), 1'b1);
      send_req(ACT_ADD, 5'd4, 5'd2);
      send_req(ACT_ADD, 5'd4, 5'd3);
      send_req(ACT_ADD, 5'd5, 5'd0);
      send_req(ACT_QUERY, 5'd31, 5'd31);
   endtask

   // Random adds and queries under one idling profile and a fresh size setting.
   task automatic test_random_traffic(input int n_items, input int send_idle,
                                      input int recv_idle);
      logic [SIZE_W-1:0] rows;
      logic [SIZE_W-1:0] cols;
      logic [IDX_W-1:0]  stim;
      logic [IDX_W-1:0]  resp;
      action_type        act;
      rows = pick_size();
      cols = pick_size();
      set_sizes(rows, cols, 1'($urandom_range(1)));
      req_idle_pct = send_idle;
      rsp_idle_pct <= recv_idle;
      stim = '0;
      resp = '0;
      for (int i = 0; i < n_items; i++) begin
         // every third of the way, sometimes resize mid-phase
         if (i % (n_items / 3) == n_items / 3 - 1 && $urandom_range(1)) begin
            rows = pick_size();
            cols = pick_size();
            set_sizes(rows, cols, 1'($urandom_range(1)));
         end
         // repeat the last cell now and then to exercise forwarding
         if (i == 0 || $urandom_range(99) >= 20) begin
            stim = pick_index(rows);
            resp = pick_index(cols);
         end
         act = ($urandom_range(99) < 70) ? ACT_ADD : ACT_QUERY;
         send_req(act, stim, resp);
      end
   endtask

   // Sender runs flat out while the receiver holds off in one long output stall,
   // so the pipeline fills and req_tready drops.
   task automatic test_output_stall();
      logic [IDX_W-1:0] stim;
      logic [IDX_W-1:0] resp;
      set_sizes(SIZE_W'(4), SIZE_W'(4), 1'b0);
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      hold_flip    <= ~hold_flip;
      for (int i = 0; i < 60; i++) begin
         stim = IDX_W'($urandom_range(3));
         resp = IDX_W'($urandom_range(3));
         send_req(($urandom_range(99) < 80) ? ACT_ADD : ACT_QUERY, stim, resp);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(290, 28, 79);
      test_random_traffic(290, 79, 28);
      test_random_traffic(290, 0, 0);
      test_output_stall();
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && tally_expect.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
